// ===== design/tgi_pkg.sv =====
// Shared constants and control types for the tile grid interpolator.
// No dependencies; imported by every module of the block but tgi_div_const.
package tgi_pkg;

   localparam int GRID_N   = 11;  // points along one side of the grid
   localparam int LAST_IDX = 10;  // index of the final row and column
   localparam int ROW_BITS = 4;
   localparam int COL_BITS = 12;  // width of every grid value on the result port

   typedef struct packed {
      logic                valid;
      logic [ROW_BITS-1:0] row;
   } row_ctl_type;

endpackage

// ===== design/tgi_div_const.sv =====
// Unsigned divide by a constant through an exact reciprocal multiply.
// No dependencies; used by tgi_lane and tile_grid_interpolator.
module tgi_div_const #(
   parameter int IN_BITS  = 16,
   parameter int OUT_BITS = 12,
   parameter int DIVISOR  = 11
) (
   input  logic [IN_BITS-1:0]  dividend,
   output logic [OUT_BITS-1:0] quotient
);
   // shift wide enough that the reciprocal error never reaches the next integer
   localparam int SHIFT     = IN_BITS + $clog2(DIVISOR);
   localparam int MULT_BITS = SHIFT + 1;
   localparam int PROD_BITS = IN_BITS + MULT_BITS;
   localparam longint unsigned MULT = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

   logic [PROD_BITS-1:0] product;

   assign product  = PROD_BITS'(dividend) * PROD_BITS'(MULT);
   assign quotient = product[SHIFT +: OUT_BITS];

endmodule

// ===== design/tgi_lane.sv =====
// One column lane: edge points of its column and the interior value of each row.
// Depends on tgi_pkg and tgi_div_const.
module tgi_lane #(
   parameter int SAMPLE_BITS = 12,
   parameter int COL         = 0
) (
   input  logic                         clock,
   input  logic [SAMPLE_BITS-1:0]       tl1,
   input  logic [SAMPLE_BITS-1:0]       tr1,
   input  logic [SAMPLE_BITS-1:0]       bl1,
   input  logic [SAMPLE_BITS-1:0]       br1,
   input  logic [tgi_pkg::ROW_BITS-1:0] row3,
   input  logic [SAMPLE_BITS-1:0]       tl3,
   input  logic [SAMPLE_BITS-1:0]       tr3,
   input  logic [SAMPLE_BITS-1:0]       bl3,
   input  logic [SAMPLE_BITS-1:0]       br3,
   input  logic [SAMPLE_BITS-1:0]       lft3,
   input  logic [SAMPLE_BITS-1:0]       rgt3,
   output logic [tgi_pkg::COL_BITS-1:0] value
);
   import tgi_pkg::*;

   localparam int NUM_BITS = SAMPLE_BITS + 4;
   localparam int SUM_BITS = SAMPLE_BITS + 6;
   localparam int W_NEAR   = GRID_N - COL;
   localparam int W_FAR    = COL;

   logic [NUM_BITS-1:0]    tnum_in, tnum_ff, bnum_in, bnum_ff;
   logic [SAMPLE_BITS-1:0] top3_in, top3_ff, bot3_in, bot3_ff;
   logic [SUM_BITS-1:0]    sum_in, sum_ff;
   logic                   diag_in, diag_ff, edge_in, edge_ff;
   logic [SAMPLE_BITS-1:0] edge_val_in, edge_val_ff;
   logic [COL_BITS-1:0]    value_in, value_ff;

   logic [ROW_BITS-1:0]    row_near;
   logic [SUM_BITS-1:0]    q_line, r_line, d_line;
   logic [SAMPLE_BITS-1:0] quot22, quot33;

   // scaled top and bottom edge points of this column
   assign tnum_in = NUM_BITS'(tl1) * NUM_BITS'(W_NEAR) + NUM_BITS'(tr1) * NUM_BITS'(W_FAR);
   assign bnum_in = NUM_BITS'(bl1) * NUM_BITS'(W_NEAR) + NUM_BITS'(br1) * NUM_BITS'(W_FAR);

   tgi_div_const #(.IN_BITS(NUM_BITS), .OUT_BITS(SAMPLE_BITS), .DIVISOR(GRID_N)) u_div_top (
      .dividend(tnum_ff), .quotient(top3_in)
   );
   tgi_div_const #(.IN_BITS(NUM_BITS), .OUT_BITS(SAMPLE_BITS), .DIVISOR(GRID_N)) u_div_bot (
      .dividend(bnum_ff), .quotient(bot3_in)
   );

   // row line, column line and diagonal line, all scaled by the grid size
   assign row_near = ROW_BITS'(GRID_N) - row3;
   assign q_line   = SUM_BITS'(lft3) * SUM_BITS'(W_NEAR) + SUM_BITS'(rgt3) * SUM_BITS'(W_FAR);
   assign r_line   = SUM_BITS'(top3_ff) * SUM_BITS'(row_near) + SUM_BITS'(bot3_ff) * SUM_BITS'(row3);
   assign d_line   = SUM_BITS'(tl3) * SUM_BITS'(W_NEAR) + SUM_BITS'(br3) * SUM_BITS'(W_FAR);
   assign diag_in  = (row3 == ROW_BITS'(COL));
   assign sum_in   = q_line + r_line + (diag_in ? d_line : '0);

   always_comb begin
      edge_in     = 1'b1;
      edge_val_in = top3_ff;
      if (row3 == ROW_BITS'(0)) begin
         edge_val_in = (COL == 0) ? tl3 : (COL == LAST_IDX) ? tr3 : top3_ff;
      end else if (row3 == ROW_BITS'(LAST_IDX)) begin
         edge_val_in = (COL == 0) ? bl3 : (COL == LAST_IDX) ? br3 : bot3_ff;
      end else if (COL == 0) begin
         edge_val_in = lft3;
      end else if (COL == LAST_IDX) begin
         edge_val_in = rgt3;
      end else begin
         edge_in = 1'b0;
      end
   end

   tgi_div_const #(.IN_BITS(SUM_BITS), .OUT_BITS(SAMPLE_BITS), .DIVISOR(2 * GRID_N)) u_div_22 (
      .dividend(sum_ff), .quotient(quot22)
   );
   tgi_div_const #(.IN_BITS(SUM_BITS), .OUT_BITS(SAMPLE_BITS), .DIVISOR(3 * GRID_N)) u_div_33 (
      .dividend(sum_ff), .quotient(quot33)
   );

   assign value_in = COL_BITS'(edge_ff ? edge_val_ff : (diag_ff ? quot33 : quot22));

   always_ff @(posedge clock) begin
      tnum_ff     <= tnum_in;
      bnum_ff     <= bnum_in;
      top3_ff     <= top3_in;
      bot3_ff     <= bot3_in;
      sum_ff      <= sum_in;
      diag_ff     <= diag_in;
      edge_ff     <= edge_in;
      edge_val_ff <= edge_val_in;
      value_ff    <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== design/tile_grid_interpolator.sv =====
// Tile grid interpolator: four corner samples in, eleven rows of an 11x11 grid out.
// Row 0 passes the stages s1 to s5 listed below before it is on the result ports.
// Throughput: one row per cycle while a tile issues, set by the row counter that feeds
// the eleven column lanes; busy drops as row 10 issues, so the next tile follows on.
// The receiver cannot stall: rows leave on strobe in consecutive cycles.
// Reset (synchronous): clears the row counter and pipeline valid bits; busy is high.
module tile_grid_interpolator #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [SAMPLE_BITS-1:0]       req_top_left,
   input  logic [SAMPLE_BITS-1:0]       req_top_right,
   input  logic [SAMPLE_BITS-1:0]       req_bottom_left,
   input  logic [SAMPLE_BITS-1:0]       req_bottom_right,
   output logic                         strobe,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_0,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_1,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_2,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_3,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_4,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_5,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_6,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_7,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_8,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_9,
   output logic [tgi_pkg::COL_BITS-1:0] rsp_col_10,
   output logic                         rsp_last_row
);
   import tgi_pkg::*;

   localparam int NUM_BITS = SAMPLE_BITS + 4;

   // Pipeline:
   //   s1  issue: corners of the current tile and the row being issued
   //   s2  scaled edge numerators (left/right here, top/bottom in each lane)
   //   s3  edge points after the divide by 11
   //   s4  interior sums per lane, edge selection
   //   s5  output register, shown with strobe
   row_ctl_type ctl1_in, ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   logic        accept;

   logic [SAMPLE_BITS-1:0] tl1_in, tl1_ff, tr1_in, tr1_ff, bl1_in, bl1_ff, br1_in, br1_ff;
   logic [SAMPLE_BITS-1:0] tl2_ff, tr2_ff, bl2_ff, br2_ff;
   logic [SAMPLE_BITS-1:0] tl3_ff, tr3_ff, bl3_ff, br3_ff;

   logic [ROW_BITS-1:0]    row_near1;
   logic [NUM_BITS-1:0]    lnum2_in, lnum2_ff, rnum2_in, rnum2_ff;
   logic [SAMPLE_BITS-1:0] lft3_in, lft3_ff, rgt3_in, rgt3_ff;

   logic [COL_BITS-1:0]    lane_value [GRID_N];

   // Hold off a new tile until its predecessor issues its last row.
   assign busy   = reset || (ctl1_ff.valid && (ctl1_ff.row != ROW_BITS'(LAST_IDX)));
   assign accept = start && !busy;

   // Row counter: start at row 0 on a new item, advance one row per cycle, drop after row 10.
   always_comb begin
      ctl1_in = ctl1_ff;
      if (accept) begin
         ctl1_in.valid = 1'b1;
         ctl1_in.row   = '0;
      end else if (ctl1_ff.valid && (ctl1_ff.row != ROW_BITS'(LAST_IDX))) begin
         ctl1_in.row   = ctl1_ff.row + ROW_BITS'(1);
      end else begin
         ctl1_in.valid = 1'b0;
      end
   end

   // Hold the corners for all eleven rows of the tile.
   assign tl1_in = accept ? req_top_left     : tl1_ff;
   assign tr1_in = accept ? req_top_right    : tr1_ff;
   assign bl1_in = accept ? req_bottom_left  : bl1_ff;
   assign br1_in = accept ? req_bottom_right : br1_ff;

   // Left and right edge points are shared by every lane of a row.
   assign row_near1 = ROW_BITS'(GRID_N) - ctl1_ff.row;
   assign lnum2_in  = NUM_BITS'(tl1_ff) * NUM_BITS'(row_near1)
                    + NUM_BITS'(bl1_ff) * NUM_BITS'(ctl1_ff.row);
   assign rnum2_in  = NUM_BITS'(tr1_ff) * NUM_BITS'(row_near1)
                    + NUM_BITS'(br1_ff) * NUM_BITS'(ctl1_ff.row);

   tgi_div_const #(.IN_BITS(NUM_BITS), .OUT_BITS(SAMPLE_BITS), .DIVISOR(GRID_N)) u_div_lft (
      .dividend(lnum2_ff), .quotient(lft3_in)
   );
   tgi_div_const #(.IN_BITS(NUM_BITS), .OUT_BITS(SAMPLE_BITS), .DIVISOR(GRID_N)) u_div_rgt (
      .dividend(rnum2_ff), .quotient(rgt3_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      tl1_ff   <= tl1_in;
      tr1_ff   <= tr1_in;
      bl1_ff   <= bl1_in;
      br1_ff   <= br1_in;
      tl2_ff   <= tl1_ff;
      tr2_ff   <= tr1_ff;
      bl2_ff   <= bl1_ff;
      br2_ff   <= br1_ff;
      tl3_ff   <= tl2_ff;
      tr3_ff   <= tr2_ff;
      bl3_ff   <= bl2_ff;
      br3_ff   <= br2_ff;
      lnum2_ff <= lnum2_in;
      rnum2_ff <= rnum2_in;
      lft3_ff  <= lft3_in;
      rgt3_ff  <= rgt3_in;
   end

   // One lane per grid column; all eleven values of a row finish together.
   for (genvar g = 0; g < GRID_N; g++) begin : g_lane
      tgi_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COL(g)) u_lane (
         .clock (clock),
         .tl1   (tl1_ff),
         .tr1   (tr1_ff),
         .bl1   (bl1_ff),
         .br1   (br1_ff),
         .row3  (ctl3_ff.row),
         .tl3   (tl3_ff),
         .tr3   (tr3_ff),
         .bl3   (bl3_ff),
         .br3   (br3_ff),
         .lft3  (lft3_ff),
         .rgt3  (rgt3_ff),
         .value (lane_value[g])
      );
   end

   // Merge the lanes into one row item.
   assign strobe       = ctl5_ff.valid;
   assign rsp_last_row = ctl5_ff.valid && (ctl5_ff.row == ROW_BITS'(LAST_IDX));
   assign rsp_col_0    = lane_value[0];
   assign rsp_col_1    = lane_value[1];
   assign rsp_col_2    = lane_value[2];
   assign rsp_col_3    = lane_value[3];
   assign rsp_col_4    = lane_value[4];
   assign rsp_col_5    = lane_value[5];
   assign rsp_col_6    = lane_value[6];
   assign rsp_col_7    = lane_value[7];
   assign rsp_col_8    = lane_value[8];
   assign rsp_col_9    = lane_value[9];
   assign rsp_col_10   = lane_value[10];

endmodule

// ===== design/tgi_checker.sv =====
// Port-level checks of the tile grid interpolator and the bind that attaches them.
// Depends on tgi_pkg and tile_grid_interpolator.
module tgi_checker #(
   parameter int SAMPLE_BITS = 12
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [SAMPLE_BITS-1:0]       req_top_left,
   input logic                         strobe,
   input logic [tgi_pkg::COL_BITS-1:0] rsp_col_0,
   input logic                         rsp_last_row
);
   import tgi_pkg::*;

   // a taken item holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an item was taken");

   // row 0 arrives a fixed latency after the item
   a_first_row_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 strobe)
      else $error("first row missing five cycles after an item was taken");

   // the top-left corner is copied into row 0, column 0
   a_corner_copied: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 (rsp_col_0 == COL_BITS'($past(req_top_left, 5))))
      else $error("top-left corner not copied to row 0");

   // rows of one tile leave in consecutive cycles until the last row
   a_rows_contiguous: assert property (@(posedge clock) disable iff (reset)
      (strobe && !rsp_last_row) |=> strobe)
      else $error("gap in the rows of a tile");

endmodule

bind tile_grid_interpolator tgi_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tgi_checker (.*);

// ===== tb/tile_grid_interpolator_tb.sv =====
// Self-checking testbench for tile_grid_interpolator: corner tiles in, 11 grid rows out.
// Depends on design/tgi_pkg.sv and design/tile_grid_interpolator.sv, which needs tgi_lane and tgi_div_const.
`timescale 1ns / 100ps

module tile_grid_interpolator_tb;
   import tgi_pkg::*;

   localparam int SAMPLE_BITS = 12;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int RANDOM_TILES = 480;
   localparam int CALM_TILES   = 60;      // final stretch driven without idle gaps
   localparam int DRAIN_CYCLES = 12;      // wait after the last queued row, to catch stray strobes
   localparam int CYCLE_LIMIT  = 200000;  // budget for about 500 tiles, many times over

   // One result row as the block presents it.
   typedef struct packed {
      logic                               last;
      logic [GRID_N-1:0][COL_BITS-1:0]    cols;
   } grid_row_type;

   // Scoreboard: expands each accepted tile into its eleven rows and checks rows in order.
   class grid_scoreboard;
      grid_row_type expected_rows[$];
      int           errors;

      function new();
         errors = 0;
      endfunction

      // Edge point p steps from a toward b; division by 11 keeps p = 10 short of b.
      function int edge_point(int a, int b, int p);
         return (a * (GRID_N - p) + b * p) / GRID_N;
      endfunction

      // Compute the full 11x11 grid for one tile and queue its rows.
      function void note_tile(int tl, int tr, int bl, int br);
         int           top_e[GRID_N];
         int           bot_e[GRID_N];
         int           lft_e[GRID_N];
         int           rgt_e[GRID_N];
         int           q_line;
         int           r_line;
         int           d_line;
         int           value;
         grid_row_type row;
         for (int p = 1; p <= LAST_IDX; p++) begin
            top_e[p] = edge_point(tl, tr, p);
            bot_e[p] = edge_point(bl, br, p);
            lft_e[p] = edge_point(tl, bl, p);
            rgt_e[p] = edge_point(tr, br, p);
         end
         top_e[0] = tl;
         lft_e[0] = tl;
         bot_e[0] = bl;
         rgt_e[0] = tr;
         for (int j = 0; j < GRID_N; j++) begin
            for (int k = 0; k < GRID_N; k++) begin
               if (j == 0) begin
                  value = (k == LAST_IDX) ? tr : top_e[k];
               end else if (j == LAST_IDX) begin
                  value = (k == 0) ? bl : (k == LAST_IDX) ? br : bot_e[k];
               end else if (k == 0) begin
                  value = lft_e[j];
               end else if (k == LAST_IDX) begin
                  value = rgt_e[j];
               end else begin
                  // Interior: average the row line and column line, plus the diagonal line.
                  q_line = lft_e[j] * (GRID_N - k) + rgt_e[j] * k;
                  r_line = top_e[k] * (GRID_N - j) + bot_e[k] * j;
                  if (j == k) begin
                     d_line = tl * (GRID_N - k) + br * k;
                     value  = (q_line + r_line + d_line) / (3 * GRID_N);
                  end else begin
                     value  = (q_line + r_line) / (2 * GRID_N);
                  end
               end
               row.cols[k] = value[COL_BITS-1:0];
            end
            row.last = (j == LAST_IDX);
            expected_rows.push_back(row);
         end
      endfunction

      function void check_row(grid_row_type got);
         grid_row_type want;
         if (expected_rows.size() == 0) begin
            $error("unexpected row: no row pending, got last_row %0b", got.last);
            errors++;
            return;
         end
         want = expected_rows.pop_front();
         for (int k = 0; k < GRID_N; k++) begin
            if (got.cols[k] !== want.cols[k]) begin
               $error("col_%0d: expected %0d, got %0d", k, want.cols[k], got.cols[k]);
               errors++;
            end
         end
         if (got.last !== want.last) begin
            $error("last_row: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [SAMPLE_BITS-1:0]  req_top_left;
   logic [SAMPLE_BITS-1:0]  req_top_right;
   logic [SAMPLE_BITS-1:0]  req_bottom_left;
   logic [SAMPLE_BITS-1:0]  req_bottom_right;
   logic                    strobe;
   logic [COL_BITS-1:0]     rsp_col_0;
   logic [COL_BITS-1:0]     rsp_col_1;
   logic [COL_BITS-1:0]     rsp_col_2;
   logic [COL_BITS-1:0]     rsp_col_3;
   logic [COL_BITS-1:0]     rsp_col_4;
   logic [COL_BITS-1:0]     rsp_col_5;
   logic [COL_BITS-1:0]     rsp_col_6;
   logic [COL_BITS-1:0]     rsp_col_7;
   logic [COL_BITS-1:0]     rsp_col_8;
   logic [COL_BITS-1:0]     rsp_col_9;
   logic [COL_BITS-1:0]     rsp_col_10;
   logic                    rsp_last_row;

   int             cycle_count = 0;
   grid_scoreboard grid_sb;

   tile_grid_interpolator #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_top_left    (req_top_left),
      .req_top_right   (req_top_right),
      .req_bottom_left (req_bottom_left),
      .req_bottom_right(req_bottom_right),
      .strobe          (strobe),
      .rsp_col_0       (rsp_col_0),
      .rsp_col_1       (rsp_col_1),
      .rsp_col_2       (rsp_col_2),
      .rsp_col_3       (rsp_col_3),
      .rsp_col_4       (rsp_col_4),
      .rsp_col_5       (rsp_col_5),
      .rsp_col_6       (rsp_col_6),
      .rsp_col_7       (rsp_col_7),
      .rsp_col_8       (rsp_col_8),
      .rsp_col_9       (rsp_col_9),
      .rsp_col_10      (rsp_col_10),
      .rsp_last_row    (rsp_last_row)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Guard against a hung block: end the run once the cycle budget is spent.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tile_grid_interpolator_tb: done, errors");
         $finish;
      end
   end

   // Rows cannot be held off: take every strobed row at the edge that ends its cycle.
   // Values read here are the pre-edge ones, so no race with the block's own updates.
   always @(posedge clock) begin
      grid_row_type got;
      if (reset === 1'b0 && strobe === 1'b1) begin
         got.cols[0]  = rsp_col_0;
         got.cols[1]  = rsp_col_1;
         got.cols[2]  = rsp_col_2;
         got.cols[3]  = rsp_col_3;
         got.cols[4]  = rsp_col_4;
         got.cols[5]  = rsp_col_5;
         got.cols[6]  = rsp_col_6;
         got.cols[7]  = rsp_col_7;
         got.cols[8]  = rsp_col_8;
         got.cols[9]  = rsp_col_9;
         got.cols[10] = rsp_col_10;
         got.last     = rsp_last_row;
         grid_sb.check_row(got);
      end
   end

   // Offer one tile after an optional idle gap; return once the block has taken it.
   // Start stays high when tiles follow back to back, so it is never dropped and
   // raised in the same step.
   task automatic send_tile(int tl, int tr, int bl, int br, int idle_cycles);
      if (idle_cycles > 0) begin
         start <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      start            <= 1'b1;
      req_top_left     <= tl[SAMPLE_BITS-1:0];
      req_top_right    <= tr[SAMPLE_BITS-1:0];
      req_bottom_left  <= bl[SAMPLE_BITS-1:0];
      req_bottom_right <= br[SAMPLE_BITS-1:0];
      // Hold until an edge sees start high with busy low.
      do @(posedge clock); while (busy !== 1'b0);
      grid_sb.note_tile(tl, tr, bl, br);
   endtask

   // Pick one corner sample: extremes often, else near a shared base or fully random.
   function automatic int pick_sample(int mode, int base);
      int v;
      case (mode)
         0: v = $urandom_range(0, SAMPLE_MAX);
         1: v = base + $urandom_range(0, 40) - 20;
         2: v = ($urandom_range(0, 2) == 0) ? 0 :
                ($urandom_range(0, 1) == 0) ? SAMPLE_MAX : $urandom_range(0, SAMPLE_MAX);
         default: v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(SAMPLE_MAX - 63, SAMPLE_MAX);
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v;
   endfunction

   initial begin
      int mode;
      int base;
      int idle_cycles;
      grid_sb          = new();
      reset            = 1'b1;
      start            = 1'b0;
      req_top_left     = '0;
      req_top_right    = '0;
      req_bottom_left  = '0;
      req_bottom_right = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed tiles: flat extremes, each corner alone at full scale and at zero,
      // opposing diagonals, alternating bit patterns and plain ramps.
      send_tile(0, 0, 0, 0, 0);
      send_tile(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0);
      send_tile(SAMPLE_MAX, 0, 0, 0, 0);
      send_tile(0, SAMPLE_MAX, 0, 0, 1);
      send_tile(0, 0, SAMPLE_MAX, 0, 0);
      send_tile(0, 0, 0, SAMPLE_MAX, 2);
      send_tile(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0);
      send_tile(SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX, 0);
      send_tile(SAMPLE_MAX, SAMPLE_MAX, 0, SAMPLE_MAX, 3);
      send_tile(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0);
      send_tile(SAMPLE_MAX, 0, 0, SAMPLE_MAX, 0);
      send_tile(0, SAMPLE_MAX, SAMPLE_MAX, 0, 1);
      send_tile('hAAA, 'h555, 'h555, 'hAAA, 0);
      send_tile('h555, 'hAAA, 'hAAA, 'h555, 0);
      send_tile(0, 10, 110, 121, 0);
      send_tile(1, 1, 1, 1, 4);
      send_tile(2048, 2047, 2049, 2046, 0);
      send_tile(4094, 1, 4093, 2, 0);

      // Random tiles; idle gaps come at random, then the tail runs flat out.
      for (int i = 0; i < RANDOM_TILES; i++) begin
         mode = $urandom_range(0, 3);
         base = $urandom_range(0, SAMPLE_MAX);
         if (i >= RANDOM_TILES - CALM_TILES || $urandom_range(0, 2) != 0) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = $urandom_range(1, 4);
         end
         send_tile(pick_sample(mode, base), pick_sample(mode, base),
                   pick_sample(mode, base), pick_sample(mode, base), idle_cycles);
      end
      start <= 1'b0;

      // Drain: wait for every queued row, then DRAIN_CYCLES more to catch stray strobes.
      while (grid_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (grid_sb.errors == 0) begin
         $display("tile_grid_interpolator_tb: done, clean");
      end else begin
         $display("tile_grid_interpolator_tb: done, errors");
      end
      $finish;
   end

endmodule
